### rtl/lbct_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lbct_pkg
// Shared constants for the LRU block cache tag store.
// ----------------------------------------------------------------------------
package lbct_pkg;

    localparam int MAX_ENTRIES_DEF   = 8;
    localparam int BLOCK_ID_BITS_DEF = 32;

    // cache_size register
    localparam int              CFG_W            = 4;
    localparam logic [CFG_W-1:0] CACHE_SIZE_RESET = 4'd2;

    // request modes
    localparam logic MODE_ACCESS = 1'b0;
    localparam logic MODE_CLEAR  = 1'b1;

endpackage
`default_nettype wire

### rtl/lru_block_cache_tags_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lru_block_cache_tags_core
// Fully associative tag store with least-recently-used replacement.
//
//   channel  signals                                   dir  transfer when
//   in       in_valid/in_ready, mode, block_id          in   in_valid & in_ready
//   out      out_valid/out_ready, hit, slot, evicted,   out  out_valid & out_ready
//            evicted_block
//   cfg      cfg_wr_en, cfg_wr_data (cache_size)        in   cfg_wr_en
//
// A clear sets the result stage at its transfer and moves on to the output register
// once that is free. An access scans the tag RAM one entry per cycle through its
// single read port, stopping at a hit; a miss scans every entry. in_ready is high
// only while the sequencer is idle; a finished result waits in its own stage until
// the output register is free, so one result can sit unclaimed while the next
// request is accepted.
// Reset clears all entries at once (valid bits in flops); cache_size resets to 2.
// ----------------------------------------------------------------------------
module lru_block_cache_tags_core #(
    parameter int MAX_ENTRIES   = lbct_pkg::MAX_ENTRIES_DEF,
    parameter int BLOCK_ID_BITS = lbct_pkg::BLOCK_ID_BITS_DEF,
    parameter int SLOT_W        = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_wr_en,
    input  wire logic [lbct_pkg::CFG_W-1:0] cfg_wr_data,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic                       mode,
    input  wire logic [BLOCK_ID_BITS-1:0]   block_id,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic                            hit,
    output logic      [SLOT_W-1:0]          slot,
    output logic                            evicted,
    output logic      [BLOCK_ID_BITS-1:0]   evicted_block
);

    import lbct_pkg::*;

    localparam int IDX_W  = SLOT_W;
    localparam int FILL_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W  = (FILL_W > CFG_W) ? FILL_W : CFG_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ENTRIES - 1);

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_UPDATE, ST_RESULT} state_t;

    state_t                   state_reg, state_next;
    logic [CFG_W-1:0]         cache_size_reg, cache_size_next;
    logic [MAX_ENTRIES-1:0]   valid_reg, valid_next;
    logic [IDX_W-1:0]         age_reg [MAX_ENTRIES];
    logic [IDX_W-1:0]         age_next [MAX_ENTRIES];
    logic [FILL_W-1:0]        fill_reg, fill_next;

    logic [BLOCK_ID_BITS-1:0] id_reg, id_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic                     issue_reg, issue_next;
    logic                     rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]         rd_idx_reg, rd_idx_next;

    logic                     found_reg, found_next;
    logic [IDX_W-1:0]         found_idx_reg, found_idx_next;
    logic [IDX_W-1:0]         found_age_reg, found_age_next;
    logic                     lru_found_reg, lru_found_next;
    logic [IDX_W-1:0]         lru_idx_reg, lru_idx_next;
    logic [BLOCK_ID_BITS-1:0] lru_block_reg, lru_block_next;
    logic                     free_found_reg, free_found_next;
    logic [IDX_W-1:0]         free_idx_reg, free_idx_next;

    logic                     res_hit_reg, res_hit_next;
    logic [IDX_W-1:0]         res_slot_reg, res_slot_next;
    logic                     res_ev_reg, res_ev_next;
    logic [BLOCK_ID_BITS-1:0] res_evb_reg, res_evb_next;

    logic                     out_valid_reg, out_valid_next;
    logic                     hit_reg, hit_next;
    logic [SLOT_W-1:0]        slot_reg, slot_next;
    logic                     evicted_reg, evicted_next;
    logic [BLOCK_ID_BITS-1:0] evicted_block_reg, evicted_block_next;

    logic                     rd_en;
    logic                     wr_en;
    logic [IDX_W-1:0]         wr_addr;
    logic [BLOCK_ID_BITS-1:0] rd_data;

    logic                     e_valid;
    logic [IDX_W-1:0]         e_age;
    logic [CMP_W-1:0]         cfg_ext;
    logic [CMP_W-1:0]         limit;
    logic                     at_limit;
    logic                     do_evict;
    logic                     keep;

    lbct_tag_ram #(
        .DEPTH  (MAX_ENTRIES),
        .WIDTH  (BLOCK_ID_BITS),
        .ADDR_W (IDX_W)
    ) u_tag_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (id_reg),
        .rd_en   (rd_en),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    // effective limit: zero counts as one, saturate at the entry count
    always_comb
    begin
        cfg_ext = CMP_W'(cache_size_reg);
        if (cfg_ext == '0)
        begin
            limit = CMP_W'(1);
        end
        else if (cfg_ext > CMP_W'(MAX_ENTRIES))
        begin
            limit = CMP_W'(MAX_ENTRIES);
        end
        else
        begin
            limit = cfg_ext;
        end
        at_limit = (CMP_W'(fill_reg) >= limit);
        do_evict = at_limit && lru_found_reg;
        // lowest free slot, unless the evicted entry sits lower or no slot is free
        if (do_evict && (!free_found_reg || (lru_idx_reg < free_idx_reg)))
        begin
            wr_addr = lru_idx_reg;
        end
        else
        begin
            wr_addr = free_idx_reg;
        end
    end

    assign e_valid = valid_reg[rd_idx_reg];
    assign e_age   = age_reg[rd_idx_reg];

    always_comb
    begin
        state_next         = state_reg;
        cache_size_next    = cfg_wr_en ? cfg_wr_data : cache_size_reg;
        valid_next         = valid_reg;
        age_next           = age_reg;
        fill_next          = fill_reg;
        id_next            = id_reg;
        idx_next           = idx_reg;
        issue_next         = issue_reg;
        rd_vld_next        = 1'b0;
        rd_idx_next        = idx_reg;
        found_next         = found_reg;
        found_idx_next     = found_idx_reg;
        found_age_next     = found_age_reg;
        lru_found_next     = lru_found_reg;
        lru_idx_next       = lru_idx_reg;
        lru_block_next     = lru_block_reg;
        free_found_next    = free_found_reg;
        free_idx_next      = free_idx_reg;
        res_hit_next       = res_hit_reg;
        res_slot_next      = res_slot_reg;
        res_ev_next        = res_ev_reg;
        res_evb_next       = res_evb_reg;
        out_valid_next     = out_valid_reg && !out_ready;
        hit_next           = hit_reg;
        slot_next          = slot_reg;
        evicted_next       = evicted_reg;
        evicted_block_next = evicted_block_reg;
        rd_en              = 1'b0;
        wr_en              = 1'b0;
        keep               = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (mode == MODE_CLEAR)
                    begin
                        valid_next = '0;
                        for (int i = 0; i < MAX_ENTRIES; i++)
                        begin
                            age_next[i] = '0;
                        end
                        fill_next    = '0;
                        res_hit_next = 1'b0;
                        res_slot_next = '0;
                        res_ev_next  = 1'b0;
                        res_evb_next = '0;
                        state_next   = ST_RESULT;
                    end
                    else
                    begin
                        id_next         = block_id;
                        idx_next        = '0;
                        issue_next      = 1'b1;
                        found_next      = 1'b0;
                        found_idx_next  = '0;
                        found_age_next  = '0;
                        lru_found_next  = 1'b0;
                        lru_idx_next    = '0;
                        lru_block_next  = '0;
                        free_found_next = 1'b0;
                        free_idx_next   = '0;
                        state_next      = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                // read issue stage
                rd_en       = issue_reg;
                rd_vld_next = issue_reg;
                if (issue_reg)
                begin
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == LAST_IDX)
                    begin
                        issue_next = 1'b0;
                    end
                end
                // compare stage, one entry behind the read
                if (rd_vld_reg)
                begin
                    if (e_valid && (rd_data == id_reg))
                    begin
                        found_next     = 1'b1;
                        found_idx_next = rd_idx_reg;
                        found_age_next = e_age;
                        issue_next     = 1'b0;
                        state_next     = ST_UPDATE;
                    end
                    else
                    begin
                        // valid ranks run 0..fill-1, so the oldest has rank fill-1
                        if (e_valid && (FILL_W'(e_age) == fill_reg - 1'b1))
                        begin
                            lru_found_next = 1'b1;
                            lru_idx_next   = rd_idx_reg;
                            lru_block_next = rd_data;
                        end
                        if (!e_valid && !free_found_reg)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next   = rd_idx_reg;
                        end
                        if (rd_idx_reg == LAST_IDX)
                        begin
                            state_next = ST_UPDATE;
                        end
                    end
                end
            end

            ST_UPDATE:
            begin
                if (found_reg)
                begin
                    for (int i = 0; i < MAX_ENTRIES; i++)
                    begin
                        if (IDX_W'(i) == found_idx_reg)
                        begin
                            age_next[i] = '0;
                        end
                        else if (valid_reg[i] && (age_reg[i] < found_age_reg))
                        begin
                            age_next[i] = age_reg[i] + 1'b1;
                        end
                    end
                    res_hit_next  = 1'b1;
                    res_slot_next = found_idx_reg;
                    res_ev_next   = 1'b0;
                    res_evb_next  = '0;
                end
                else
                begin
                    wr_en = 1'b1;
                    for (int i = 0; i < MAX_ENTRIES; i++)
                    begin
                        keep = valid_reg[i] && !(do_evict && (IDX_W'(i) == lru_idx_reg));
                        if (IDX_W'(i) == wr_addr)
                        begin
                            valid_next[i] = 1'b1;
                            age_next[i]   = '0;
                        end
                        else
                        begin
                            valid_next[i] = keep;
                            age_next[i]   = keep ? age_reg[i] + 1'b1 : '0;
                        end
                    end
                    fill_next     = do_evict ? fill_reg : fill_reg + 1'b1;
                    res_hit_next  = 1'b0;
                    res_slot_next = wr_addr;
                    res_ev_next   = do_evict;
                    res_evb_next  = do_evict ? lru_block_reg : '0;
                end
                state_next = ST_RESULT;
            end

            ST_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next     = 1'b1;
                    hit_next           = res_hit_reg;
                    slot_next          = res_slot_reg;
                    evicted_next       = res_ev_reg;
                    evicted_block_next = res_evb_reg;
                    state_next         = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            cache_size_reg    <= CACHE_SIZE_RESET;
            valid_reg         <= '0;
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                age_reg[i] <= '0;
            end
            fill_reg          <= '0;
            id_reg            <= '0;
            idx_reg           <= '0;
            issue_reg         <= 1'b0;
            rd_vld_reg        <= 1'b0;
            rd_idx_reg        <= '0;
            found_reg         <= 1'b0;
            found_idx_reg     <= '0;
            found_age_reg     <= '0;
            lru_found_reg     <= 1'b0;
            lru_idx_reg       <= '0;
            lru_block_reg     <= '0;
            free_found_reg    <= 1'b0;
            free_idx_reg      <= '0;
            res_hit_reg       <= 1'b0;
            res_slot_reg      <= '0;
            res_ev_reg        <= 1'b0;
            res_evb_reg       <= '0;
            out_valid_reg     <= 1'b0;
            hit_reg           <= 1'b0;
            slot_reg          <= '0;
            evicted_reg       <= 1'b0;
            evicted_block_reg <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            cache_size_reg    <= cache_size_next;
            valid_reg         <= valid_next;
            age_reg           <= age_next;
            fill_reg          <= fill_next;
            id_reg            <= id_next;
            idx_reg           <= idx_next;
            issue_reg         <= issue_next;
            rd_vld_reg        <= rd_vld_next;
            rd_idx_reg        <= rd_idx_next;
            found_reg         <= found_next;
            found_idx_reg     <= found_idx_next;
            found_age_reg     <= found_age_next;
            lru_found_reg     <= lru_found_next;
            lru_idx_reg       <= lru_idx_next;
            lru_block_reg     <= lru_block_next;
            free_found_reg    <= free_found_next;
            free_idx_reg      <= free_idx_next;
            res_hit_reg       <= res_hit_next;
            res_slot_reg      <= res_slot_next;
            res_ev_reg        <= res_ev_next;
            res_evb_reg       <= res_evb_next;
            out_valid_reg     <= out_valid_next;
            hit_reg           <= hit_next;
            slot_reg          <= slot_next;
            evicted_reg       <= evicted_next;
            evicted_block_reg <= evicted_block_next;
        end
    end

    assign in_ready      = (state_reg == ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign hit           = hit_reg;
    assign slot          = slot_reg;
    assign evicted       = evicted_reg;
    assign evicted_block = evicted_block_reg;

`ifndef NO_ASSERTIONS
    a_fill_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(fill_reg))
        else $error("fill count differs from number of valid entries");

    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(MAX_ENTRIES))
        else $error("fill count above entry count");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (mode == MODE_CLEAR)) |=> (valid_reg == '0))
        else $error("clear left valid entries");

    a_no_hit_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(hit && evicted))
        else $error("hit and eviction reported together");

    a_evb_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !evicted) |-> (evicted_block == '0))
        else $error("evicted block nonzero without eviction");
`endif

endmodule
`default_nettype wire

### rtl/lbct_tag_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lbct_tag_ram
// Block id storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lbct_tag_ram #(
    parameter int DEPTH = lbct_pkg::MAX_ENTRIES_DEF,
    parameter int WIDTH = lbct_pkg::BLOCK_ID_BITS_DEF,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

### dv/lru_tag_checker.sv
// ----------------------------------------------------------------------------
// lru_tag_checker
// Watches the request, result and cache_size ports of the LRU tag store,
// keeps its own copy of the tag array and recency ranks, and checks each
// result transfer against the oldest predicted result.
// ----------------------------------------------------------------------------
module lru_tag_checker (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_wr_en,
    input  logic [lbct_pkg::CFG_W-1:0]             cfg_wr_data,
    input  logic                                   in_valid,
    input  logic                                   in_ready,
    input  logic                                   mode,
    input  logic [lbct_pkg::BLOCK_ID_BITS_DEF-1:0] block_id,
    input  logic                                   out_valid,
    input  logic                                   out_ready,
    input  logic                                   hit,
    input  logic [2:0]                             slot,
    input  logic                                   evicted,
    input  logic [lbct_pkg::BLOCK_ID_BITS_DEF-1:0] evicted_block,
    output int                                     errors,
    output int                                     pending,
    output int                                     hits,
    output int                                     evictions
);
    timeunit 1ns;
    timeprecision 1ps;

    import lbct_pkg::*;

    localparam int ENTRIES = MAX_ENTRIES_DEF;
    localparam int ID_W    = BLOCK_ID_BITS_DEF;
    localparam int SLOT_W  = $clog2(ENTRIES);

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic              evicted;
        logic [ID_W-1:0]   victim;
    } tag_result_t;

    logic              line_valid [ENTRIES];
    logic [ID_W-1:0]   line_tag   [ENTRIES];
    logic [SLOT_W-1:0] line_rank  [ENTRIES];   // 0 = most recent
    int unsigned       occupancy;
    logic [CFG_W-1:0]  size_reg;

    tag_result_t       pending_results [$];
    int                n_err;
    int                n_hit;
    int                n_evict;

    function automatic int unsigned active_limit();
        if (size_reg == '0)
            return 1;
        if (size_reg > ENTRIES)
            return ENTRIES;
        return int'(size_reg);
    endfunction

    function automatic void clear_lines();
        for (int i = 0; i < ENTRIES; i++)
        begin
            line_valid[i] = 1'b0;
            line_tag[i]   = '0;
            line_rank[i]  = '0;
        end
        occupancy = 0;
    endfunction

    function automatic tag_result_t predict_lookup(input logic req_mode,
                                                   input logic [ID_W-1:0] id);
        tag_result_t       r;
        int                found;
        int                lru;
        int                free_idx;
        logic [SLOT_W-1:0] age;

        r        = '0;
        found    = -1;
        lru      = -1;
        free_idx = -1;
        if (req_mode == MODE_CLEAR)
        begin
            clear_lines();
            return r;
        end

        for (int i = 0; i < ENTRIES; i++)
            if (found < 0 && line_valid[i] && line_tag[i] == id)
                found = i;

        if (found >= 0)
        begin
            age = line_rank[found];
            for (int i = 0; i < ENTRIES; i++)
                if (line_valid[i] && line_rank[i] < age)
                    line_rank[i]++;
            line_rank[found] = '0;
            r.hit  = 1'b1;
            r.slot = SLOT_W'(found);
            return r;
        end

        // miss: make room first if at or above the limit
        if (occupancy >= active_limit())
        begin
            for (int i = 0; i < ENTRIES; i++)
                if (line_valid[i] && (lru < 0 || line_rank[i] > line_rank[lru]))
                    lru = i;
            if (lru >= 0)
            begin
                r.evicted       = 1'b1;
                r.victim        = line_tag[lru];
                line_valid[lru] = 1'b0;
                line_rank[lru]  = '0;
                occupancy--;
            end
        end

        for (int i = 0; i < ENTRIES; i++)
            if (free_idx < 0 && !line_valid[i])
                free_idx = i;

        if (free_idx >= 0)
        begin
            for (int i = 0; i < ENTRIES; i++)
                if (line_valid[i])
                    line_rank[i]++;
            line_valid[free_idx] = 1'b1;
            line_tag[free_idx]   = id;
            line_rank[free_idx]  = '0;
            occupancy++;
            r.slot = SLOT_W'(free_idx);
        end
        return r;
    endfunction

    task automatic flag(input string msg);
        n_err++;
        if (n_err <= 10)
            $display("%0t ns: %s", $realtime, msg);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        tag_result_t got;
        tag_result_t want;

        if (!rst_n)
        begin
            clear_lines();
            size_reg = CACHE_SIZE_RESET;
            pending_results.delete();
            n_err     = 0;
            n_hit     = 0;
            n_evict   = 0;
            errors    <= 0;
            pending   <= 0;
            hits      <= 0;
            evictions <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                size_reg = cfg_wr_data;

            if (out_valid && out_ready)
            begin
                got.hit     = hit;
                got.slot    = slot;
                got.evicted = evicted;
                got.victim  = evicted_block;
                if (pending_results.size() == 0)
                    flag($sformatf("result transfer with no request outstanding: %p", got));
                else
                begin
                    want = pending_results.pop_front();
                    if (got.hit !== want.hit || got.slot !== want.slot ||
                        got.evicted !== want.evicted || got.victim !== want.victim)
                        flag($sformatf({"result mismatch: exp hit=%0b slot=%0d ev=%0b ",
                                        "victim=%h, got hit=%0b slot=%0d ev=%0b victim=%h"},
                                       want.hit, want.slot, want.evicted, want.victim,
                                       got.hit, got.slot, got.evicted, got.victim));
                    if (want.hit)
                        n_hit++;
                    if (want.evicted)
                        n_evict++;
                end
            end

            if (in_valid && in_ready)
                pending_results.push_back(predict_lookup(mode, block_id));

            errors    <= n_err;
            pending   <= pending_results.size();
            hits      <= n_hit;
            evictions <= n_evict;
        end
    end

endmodule

### dv/tb_lru_block_cache_tags_core.sv
// ----------------------------------------------------------------------------
// tb_lru_block_cache_tags_core
// Drives lookups and clears into the LRU tag store under several cache_size
// values, with random gaps and output stalls; lru_tag_checker scores results.
// ----------------------------------------------------------------------------
module tb_lru_block_cache_tags_core;
    timeunit 1ns;
    timeprecision 1ps;

    import lbct_pkg::*;

    logic                         clk         = 1'b0;
    logic                         rst_n       = 1'b0;
    logic                         cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0]             cfg_wr_data = '0;
    logic                         in_valid    = 1'b0;
    logic                         in_ready;
    logic                         mode        = MODE_ACCESS;
    logic [BLOCK_ID_BITS_DEF-1:0] block_id    = '0;
    logic                         out_valid;
    logic                         out_ready   = 1'b0;
    logic                         hit;
    logic [2:0]                   slot;
    logic                         evicted;
    logic [BLOCK_ID_BITS_DEF-1:0] evicted_block;

    int errors;
    int pending;
    int hits;
    int evictions;

    int tx_max = 8;     // longest request gap for the current phase
    int rx_max = 8;     // longest output stall for the current phase
    int rx_left = 0;
    int n_req = 0;
    int n_clear = 0;
    int n_cfg = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    lru_block_cache_tags_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .block_id      (block_id),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .hit           (hit),
        .slot          (slot),
        .evicted       (evicted),
        .evicted_block (evicted_block)
    );

    lru_tag_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .block_id      (block_id),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .hit           (hit),
        .slot          (slot),
        .evicted       (evicted),
        .evicted_block (evicted_block),
        .errors        (errors),
        .pending       (pending),
        .hits          (hits),
        .evictions     (evictions)
    );

    // result side: after each transfer hold ready low for a drawn number of cycles
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_left   = 0;
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
                rx_left = (rx_max == 0) ? 0 : $urandom_range(0, rx_max);
            else if (rx_left > 0)
                rx_left--;
            out_ready <= (rx_left == 0);
        end
    end

    // valid stays up between back-to-back requests; only a gap or settle() lowers it
    task automatic issue_request(input logic req_mode, input logic [31:0] id);
        int gap;

        gap = (tx_max == 0) ? 0 : $urandom_range(0, tx_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= req_mode;
        block_id <= id;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        n_req++;
        if (req_mode == MODE_CLEAR)
            n_clear++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_cache_size(input logic [CFG_W-1:0] value);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        n_cfg++;
    endtask

    initial
    begin
        logic [31:0]      pool [16];
        logic [31:0]      fill_id [8];
        logic [CFG_W-1:0] sz;
        int               pool_n;
        int               roll;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset limit of two: extreme ids, hit, LRU eviction, clear
        issue_request(MODE_ACCESS, 32'h0000_0000);
        issue_request(MODE_ACCESS, 32'hFFFF_FFFF);
        issue_request(MODE_ACCESS, 32'h0000_0000);
        issue_request(MODE_ACCESS, 32'h1234_5678);
        issue_request(MODE_CLEAR,  32'hFFFF_FFFF);
        issue_request(MODE_ACCESS, 32'hFFFF_FFFF);

        // full capacity: fill all slots, hit the last and first, then evict
        write_cache_size(4'd8);
        for (int i = 0; i < 8; i++)
        begin
            fill_id[i] = 32'h8000_0001 + i * 32'h1111_1111;
            issue_request(MODE_ACCESS, fill_id[i]);
        end
        issue_request(MODE_ACCESS, fill_id[7]);
        issue_request(MODE_ACCESS, fill_id[0]);
        issue_request(MODE_ACCESS, 32'h5A5A_A5A5);

        // limit dropped under occupancy: every miss evicts, hits still work
        write_cache_size(4'd1);
        issue_request(MODE_ACCESS, 32'h0F0F_F0F0);
        issue_request(MODE_ACCESS, 32'hF0F0_0F0F);
        issue_request(MODE_ACCESS, fill_id[0]);

        // zero acts as one, all ones saturates at the array size
        write_cache_size(4'd0);
        issue_request(MODE_ACCESS, 32'h7FFF_FFFF);
        write_cache_size(4'd15);
        issue_request(MODE_ACCESS, 32'hFFFF_FFFE);
        issue_request(MODE_CLEAR,  32'h0000_0000);

        // random phases: ids drawn mostly from a small pool so hits and
        // evictions are frequent, with some one-off ids and clears
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:       sz = 4'd1;
                1:       sz = 4'd8;
                2:       sz = 4'd0;
                3:       sz = 4'd15;
                default: sz = CFG_W'($urandom_range(2, 7));
            endcase
            case (ph % 3)
                0:       begin tx_max = 8; rx_max = 8; end
                1:       begin tx_max = 0; rx_max = 0; end
                default: begin tx_max = 8; rx_max = 0; end
            endcase
            write_cache_size(sz);
            pool_n = ((sz == 0) ? 1 : (sz > 8) ? 8 : int'(sz)) + $urandom_range(1, 3);
            for (int k = 0; k < pool_n; k++)
                pool[k] = $urandom;
            for (int n = 0; n < 75; n++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 3)
                    issue_request(MODE_CLEAR, $urandom);
                else if (roll < 13)
                    issue_request(MODE_ACCESS, $urandom);
                else
                    issue_request(MODE_ACCESS, pool[$urandom_range(0, pool_n - 1)]);
            end
        end

        settle();
        repeat (20) @(posedge clk);

        $display("Sent %0d requests (%0d clears), %0d cache_size writes (0, 1, 8, 15, mid)",
                 n_req, n_clear, n_cfg);
        $display("Scored %0d hits and %0d evictions", hits, evictions);
        if (pending != 0)
            $display("%0d requests still awaiting a result", pending);
        if (errors == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Timeout with %0d results outstanding", pending);
        $display("DONE: errors detected");
        $finish;
    end

endmodule

### filelist.f
rtl/lbct_pkg.sv
rtl/lbct_tag_ram.sv
rtl/lru_block_cache_tags_core.sv
dv/lru_tag_checker.sv
dv/tb_lru_block_cache_tags_core.sv
